### rtl/swd_pkg.sv
// Shared register layout, routing codes, scaling constants and config type for the stereo matrix.
package swd_pkg;

	// Register field widths
	localparam int BAL_W   = 17;
	localparam int MODE_W  = 3;
	localparam int GAIN_W  = 18;
	localparam int WIDTH_W = 16;
	localparam int DLY_W   = 11;
	localparam int FLAG_W  = 4;
	localparam int COEF_W  = 16;

	// Configuration port
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_BAL_IN  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BAL_OUT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MODE    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MID     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SIDE    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DELAY   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_FLAGS   = 3'd7;

	// Routing modes
	localparam logic [MODE_W-1:0] MODE_LR       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TO_MS    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MS_TO_LR = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LL       = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RR       = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SUM      = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SWAP     = 3'd6;

	// Channel flag bits
	localparam int FLAG_INV_L  = 0;
	localparam int FLAG_INV_R  = 1;
	localparam int FLAG_MUTE_L = 2;
	localparam int FLAG_MUTE_R = 3;

	// Reset values
	localparam logic [GAIN_W-1:0]  GAIN_UNITY  = 18'd4096;
	localparam logic [WIDTH_W-1:0] WIDTH_UNITY = 16'd16384;

	// Fixed-point shifts and rounding offsets
	localparam int BAL_SHIFT = 15;
	localparam int MS_SHIFT  = 13;
	localparam int WID_SHIFT = 14;
	localparam int BAL_RND   = 1 << (BAL_SHIFT - 1);
	localparam int MS_RND    = 1 << (MS_SHIFT - 1);
	localparam int WID_RND   = 1 << (WID_SHIFT - 1);

	localparam int MAX_HAAS = 960;
	localparam logic signed [BAL_W-1:0] BAL_ONE = 17'sd32768;

	typedef struct packed {
		logic signed [BAL_W-1:0] bal_in;
		logic signed [BAL_W-1:0] bal_out;
		logic [MODE_W-1:0]       routing_mode;
		logic [GAIN_W-1:0]       mid_gain;
		logic [GAIN_W-1:0]       side_gain;
		logic [WIDTH_W-1:0]      stereo_width;
		logic signed [DLY_W-1:0] delay_samples;
		logic [FLAG_W-1:0]       channel_flags;
	} cfg_t;

	// Gain applied to the attenuated channel: 32768 - |b|, with b clamped to +-32768.
	function automatic logic [COEF_W-1:0] bal_coef(input logic signed [BAL_W-1:0] b);
		logic [BAL_W-1:0]  mag;
		logic [COEF_W-1:0] k;
		mag = b[BAL_W-1] ? unsigned'(-b) : unsigned'(b);
		if (b >= BAL_ONE || b <= -BAL_ONE) begin
			k = '0;
		end else begin
			k = COEF_W'(unsigned'(BAL_ONE) - mag);
		end
		return k;
	endfunction

endpackage

### rtl/swd_front.sv
// Front end: input transfer, input balance, mid/side gains, width, routing and saturation.
module swd_front #(
	parameter int SB = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swd_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [SB-1:0] left_in,
	input  logic signed [SB-1:0] right_in,
	output logic                 push,
	input  logic                 full,
	output logic signed [SB-1:0] push_left,
	output logic signed [SB-1:0] push_right
);
	import swd_pkg::*;

	localparam int PB  = SB + BAL_W;
	localparam int M2W = SB + 1;
	localparam int MPW = M2W + GAIN_W + 1;
	localparam int MW  = MPW - MS_SHIFT;
	localparam int WPW = MW + WIDTH_W + 1;
	localparam int WW  = WPW - WID_SHIFT;
	localparam int OW  = WW + 1;

	localparam longint SAT_HI_L = (longint'(1) <<< (SB - 1)) - 1;
	localparam longint SAT_LO_L = -SAT_HI_L - 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BAL  = 3'd1;
	localparam logic [2:0] ST_MS   = 3'd2;
	localparam logic [2:0] ST_WID  = 3'd3;
	localparam logic [2:0] ST_PUSH = 3'd4;

	function automatic logic signed [SB-1:0] sat_o(input logic signed [OW-1:0] x);
		logic signed [SB-1:0] y;
		if (x > OW'(SAT_HI_L)) begin
			y = SB'(SAT_HI_L);
		end else if (x < OW'(SAT_LO_L)) begin
			y = SB'(SAT_LO_L);
		end else begin
			y = SB'(x);
		end
		return y;
	endfunction

	logic [2:0] state_q;

	logic signed [SB-1:0]  lin_q, rin_q, lb_q, rb_q;
	logic signed [PB-1:0]  bp_q;
	logic signed [MPW-1:0] mp_q, sp_q;
	logic signed [MW-1:0]  mid_q, side_q;
	logic signed [WPW-1:0] wp_q;

	logic                  scale_r;
	logic [COEF_W-1:0]     bal_k;
	logic signed [SB-1:0]  bal_src, bal_val, lb, rb;
	logic signed [PB-1:0]  bp_d, bp_bias, bp_sum;
	logic signed [M2W-1:0] m2, s2;
	logic signed [MPW-1:0] mp_d, sp_d, mp_bias, sp_bias, mp_sum, sp_sum;
	logic signed [MW-1:0]  mid_d, side_d;
	logic signed [WPW-1:0] wp_d, wp_bias, wp_sum;
	logic signed [WW-1:0]  w_d;
	logic signed [OW-1:0]  ol, orr;

	// Input balance: only one channel is scaled; zero balance gives unity.
	assign scale_r = cfg.bal_in[BAL_W-1];
	assign bal_k   = bal_coef(cfg.bal_in);
	assign bal_src = scale_r ? rin_q : lin_q;
	assign bp_d    = bal_src * $signed({1'b0, bal_k});

	assign bp_bias = bp_q[PB-1] ? PB'(BAL_RND - 1) : PB'(BAL_RND);
	assign bp_sum  = bp_q + bp_bias;
	assign bal_val = SB'(bp_sum >>> BAL_SHIFT);
	assign lb      = scale_r ? lin_q : bal_val;
	assign rb      = scale_r ? bal_val : rin_q;

	assign m2   = M2W'(lb) + M2W'(rb);
	assign s2   = M2W'(lb) - M2W'(rb);
	assign mp_d = m2 * $signed({1'b0, cfg.mid_gain});
	assign sp_d = s2 * $signed({1'b0, cfg.side_gain});

	assign mp_bias = mp_q[MPW-1] ? MPW'(MS_RND - 1) : MPW'(MS_RND);
	assign sp_bias = sp_q[MPW-1] ? MPW'(MS_RND - 1) : MPW'(MS_RND);
	assign mp_sum  = mp_q + mp_bias;
	assign sp_sum  = sp_q + sp_bias;
	assign mid_d   = MW'(mp_sum >>> MS_SHIFT);
	assign side_d  = MW'(sp_sum >>> MS_SHIFT);
	assign wp_d    = side_d * $signed({1'b0, cfg.stereo_width});

	assign wp_bias = wp_q[WPW-1] ? WPW'(WID_RND - 1) : WPW'(WID_RND);
	assign wp_sum  = wp_q + wp_bias;
	assign w_d     = WW'(wp_sum >>> WID_SHIFT);

	always_comb begin
		case (cfg.routing_mode)
			MODE_TO_MS: begin
				ol  = OW'(mid_q);
				orr = OW'(side_q);
			end
			MODE_MS_TO_LR: begin
				ol  = OW'(lb_q) + OW'(rb_q);
				orr = OW'(lb_q) - OW'(rb_q);
			end
			MODE_LL: begin
				ol  = OW'(lb_q);
				orr = OW'(lb_q);
			end
			MODE_RR: begin
				ol  = OW'(rb_q);
				orr = OW'(rb_q);
			end
			MODE_SUM: begin
				ol  = OW'(lb_q) + OW'(rb_q);
				orr = OW'(lb_q) + OW'(rb_q);
			end
			MODE_SWAP: begin
				ol  = OW'(rb_q);
				orr = OW'(lb_q);
			end
			default: begin
				ol  = OW'(mid_q) + OW'(w_d);
				orr = OW'(mid_q) - OW'(w_d);
			end
		endcase
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign push       = (state_q == ST_PUSH) && !full;
	assign push_left  = sat_o(ol);
	assign push_right = sat_o(orr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_BAL;
				ST_BAL:  state_q <= ST_MS;
				ST_MS:   state_q <= ST_WID;
				ST_WID:  state_q <= ST_PUSH;
				ST_PUSH: if (!full) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					lin_q <= left_in;
					rin_q <= right_in;
				end
			end
			ST_BAL: bp_q <= bp_d;
			ST_MS: begin
				lb_q <= lb;
				rb_q <= rb;
				mp_q <= mp_d;
				sp_q <= sp_d;
			end
			ST_WID: begin
				mid_q  <= mid_d;
				side_q <= side_d;
				wp_q   <= wp_d;
			end
			default: ;
		endcase
	end

endmodule

### rtl/swd_queue.sv
// Two-entry queue carrying routed sample pairs from the front end to the back end.
module swd_queue #(
	parameter int W = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	logic [W-1:0] ent_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/swd_back.sv
// Back end: Haas delay rings, invert and mute, output balance and the output register.
module swd_back #(
	parameter int SB    = 24,
	parameter int DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swd_pkg::cfg_t        cfg,
	input  logic                 q_empty,
	input  logic signed [SB-1:0] q_left,
	input  logic signed [SB-1:0] q_right,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [SB-1:0] left_out,
	output logic signed [SB-1:0] right_out
);
	import swd_pkg::*;

	localparam int AW  = $clog2(DEPTH);
	localparam int AW1 = AW + 1;
	localparam int LIM = (DEPTH - 1 < MAX_HAAS) ? DEPTH - 1 : MAX_HAAS;
	localparam int PB  = SB + BAL_W;

	localparam longint SAT_HI_L = (longint'(1) <<< (SB - 1)) - 1;
	localparam longint SAT_LO_L = -SAT_HI_L - 1;
	localparam logic signed [SB-1:0] S_MAX = SB'(SAT_HI_L);
	localparam logic signed [SB-1:0] S_MIN = SB'(SAT_LO_L);

	function automatic logic signed [SB-1:0] neg_sat(input logic signed [SB-1:0] x);
		return (x == S_MIN) ? S_MAX : -x;
	endfunction

	// Delay rings
	logic signed [SB-1:0] lmem [DEPTH];
	logic signed [SB-1:0] rmem [DEPTH];

	logic [AW-1:0] lwp_q, rwp_q;
	logic          lwrap_q, rwrap_q;

	logic              dly_pos, dly_neg, tap, hit;
	logic [DLY_W-1:0]  dmag;
	logic [AW-1:0]     dlim, pos, pos_next, rd;

	// Pipeline state
	logic v1_q, v2_q, ov_q;
	logic adv2, out_take;

	logic signed [SB-1:0] l_s1, r_s1, lrd_s1, rrd_s1;
	logic                 dl_s1, dr_s1, hit_s1;
	logic signed [PB-1:0] bp_s2;
	logic signed [SB-1:0] oth_s2;
	logic                 sr_s2;
	logic signed [SB-1:0] lo_q, ro_q;

	logic signed [SB-1:0] lv, rv, li, ri, lm, rm, bsrc, bal_val;
	logic [COEF_W-1:0]    bk;
	logic                 sr;
	logic signed [PB-1:0] bp_d, bp_bias, bp_sum;

	// Delay magnitude, clamped to the ring and to the Haas limit
	assign dly_neg  = cfg.delay_samples[DLY_W-1];
	assign dly_pos  = !dly_neg && (cfg.delay_samples != '0);
	assign dmag     = dly_neg ? unsigned'(-cfg.delay_samples) : unsigned'(cfg.delay_samples);
	assign dlim     = (dmag > DLY_W'(LIM)) ? AW'(LIM) : AW'(dmag);
	assign tap      = (dlim != '0);
	assign pos      = dly_pos ? rwp_q : lwp_q;
	assign pos_next = (pos == AW'(DEPTH - 1)) ? '0 : pos + 1'b1;
	assign rd       = (pos >= dlim) ? AW'(pos - dlim)
	                                : AW'(AW1'(pos) + AW1'(DEPTH) - AW1'(dlim));
	// Before the first wrap only slots up to the write position hold data.
	assign hit      = (dly_pos ? rwrap_q : lwrap_q) || (rd <= pos);

	assign out_take = v2_q && (!ov_q || out_ready);
	assign adv2     = v1_q && (!v2_q || out_take);
	assign pop      = !q_empty && (!v1_q || adv2);

	always_ff @(posedge clk) begin
		if (pop && dly_neg) begin
			lmem[pos] <= q_left;
			lrd_s1    <= lmem[rd];
		end
	end

	always_ff @(posedge clk) begin
		if (pop && dly_pos) begin
			rmem[pos] <= q_right;
			rrd_s1    <= rmem[rd];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lwp_q   <= '0;
			rwp_q   <= '0;
			lwrap_q <= 1'b0;
			rwrap_q <= 1'b0;
		end else if (pop) begin
			if (dly_neg) begin
				lwp_q <= pos_next;
				if (pos == AW'(DEPTH - 1)) lwrap_q <= 1'b1;
			end
			if (dly_pos) begin
				rwp_q <= pos_next;
				if (pos == AW'(DEPTH - 1)) rwrap_q <= 1'b1;
			end
		end
	end

	// Stage 2: pick delayed samples, invert and mute, output balance product
	assign lv = dl_s1 ? (hit_s1 ? lrd_s1 : '0) : l_s1;
	assign rv = dr_s1 ? (hit_s1 ? rrd_s1 : '0) : r_s1;
	assign li = cfg.channel_flags[FLAG_INV_L] ? neg_sat(lv) : lv;
	assign ri = cfg.channel_flags[FLAG_INV_R] ? neg_sat(rv) : rv;
	assign lm = cfg.channel_flags[FLAG_MUTE_L] ? '0 : li;
	assign rm = cfg.channel_flags[FLAG_MUTE_R] ? '0 : ri;

	assign sr   = cfg.bal_out[BAL_W-1];
	assign bk   = bal_coef(cfg.bal_out);
	assign bsrc = sr ? rm : lm;
	assign bp_d = bsrc * $signed({1'b0, bk});

	assign bp_bias = bp_s2[PB-1] ? PB'(BAL_RND - 1) : PB'(BAL_RND);
	assign bp_sum  = bp_s2 + bp_bias;
	assign bal_val = SB'(bp_sum >>> BAL_SHIFT);

	always_ff @(posedge clk) begin
		if (pop) begin
			l_s1   <= q_left;
			r_s1   <= q_right;
			dl_s1  <= dly_neg && tap;
			dr_s1  <= dly_pos && tap;
			hit_s1 <= hit;
		end
		if (adv2) begin
			bp_s2  <= bp_d;
			oth_s2 <= sr ? lm : rm;
			sr_s2  <= sr;
		end
		if (out_take) begin
			lo_q <= sr_s2 ? oth_s2 : bal_val;
			ro_q <= sr_s2 ? bal_val : oth_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (pop) begin
				v1_q <= 1'b1;
			end else if (adv2) begin
				v1_q <= 1'b0;
			end
			if (adv2) begin
				v2_q <= 1'b1;
			end else if (out_take) begin
				v2_q <= 1'b0;
			end
			if (out_take) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
	assign left_out  = lo_q;
	assign right_out = ro_q;

endmodule

### rtl/stereo_matrix_width_delay.sv
// Top level of the stereo matrix: register file, front end, queue and back end.
//
//   channel   signals                                   width          direction
//   input     in_valid, in_ready, left_in, right_in     SAMPLE_BITS    in
//   output    out_valid, out_ready, left_out, right_out SAMPLE_BITS    out
//   config    psel, penable, pwrite, paddr, pwdata,     5-bit addr,    in/out
//             prdata, pready                            32-bit data
//
// Flow: the front end takes a new pair only after pushing the last one (transfer, input
// balance, mid/side gains, width, routing); the three-stage back end takes one a cycle,
// unless its output register waits for out_ready, and sets no limit.
// Reset clears control state only; ring slots not written since reset read as zero.
// Stalls: the front end holds its result while the two-entry queue is full, and the back
// end holds in place while the output register waits for out_ready.
module stereo_matrix_width_delay #(
	parameter int DELAY_DEPTH = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swd_pkg::ADDR_W-1:0]    paddr,
	input  logic [swd_pkg::DATA_W-1:0]    pwdata,
	output logic [swd_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out
);
	import swd_pkg::*;

	localparam int SB = SAMPLE_BITS;

	// Register file
	logic signed [BAL_W-1:0] bal_in_q, bal_out_q;
	logic [MODE_W-1:0]       mode_q;
	logic [GAIN_W-1:0]       mid_gain_q, side_gain_q;
	logic [WIDTH_W-1:0]      width_q;
	logic signed [DLY_W-1:0] delay_q;
	logic [FLAG_W-1:0]       flags_q;

	logic                    cfg_wr;
	logic [REG_IDX_W-1:0]    reg_idx;
	cfg_t                    cfg;

	// Front-to-back queue
	logic                 q_push, q_full, q_pop, q_empty;
	logic signed [SB-1:0] f_left, f_right;
	logic [2*SB-1:0]      q_dout;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	// Users must change registers only while the datapath is idle; the block does not enforce it. Stages read them live.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bal_in_q    <= '0;
			bal_out_q   <= '0;
			mode_q      <= MODE_LR;
			mid_gain_q  <= GAIN_UNITY;
			side_gain_q <= GAIN_UNITY;
			width_q     <= WIDTH_UNITY;
			delay_q     <= '0;
			flags_q     <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_BAL_IN:  bal_in_q    <= pwdata[BAL_W-1:0];
				REG_BAL_OUT: bal_out_q   <= pwdata[BAL_W-1:0];
				REG_MODE:    mode_q      <= pwdata[MODE_W-1:0];
				REG_MID:     mid_gain_q  <= pwdata[GAIN_W-1:0];
				REG_SIDE:    side_gain_q <= pwdata[GAIN_W-1:0];
				REG_WIDTH:   width_q     <= pwdata[WIDTH_W-1:0];
				REG_DELAY:   delay_q     <= pwdata[DLY_W-1:0];
				REG_FLAGS:   flags_q     <= pwdata[FLAG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back; signed fields come back sign-extended.
	always_comb begin
		case (reg_idx)
			REG_BAL_IN:  prdata = {{(DATA_W - BAL_W){bal_in_q[BAL_W-1]}}, bal_in_q};
			REG_BAL_OUT: prdata = {{(DATA_W - BAL_W){bal_out_q[BAL_W-1]}}, bal_out_q};
			REG_MODE:    prdata = DATA_W'(mode_q);
			REG_MID:     prdata = DATA_W'(mid_gain_q);
			REG_SIDE:    prdata = DATA_W'(side_gain_q);
			REG_WIDTH:   prdata = DATA_W'(width_q);
			REG_DELAY:   prdata = {{(DATA_W - DLY_W){delay_q[DLY_W-1]}}, delay_q};
			REG_FLAGS:   prdata = DATA_W'(flags_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.bal_in        = bal_in_q;
	assign cfg.bal_out       = bal_out_q;
	assign cfg.routing_mode  = mode_q;
	assign cfg.mid_gain      = mid_gain_q;
	assign cfg.side_gain     = side_gain_q;
	assign cfg.stereo_width  = width_q;
	assign cfg.delay_samples = delay_q;
	assign cfg.channel_flags = flags_q;

	swd_front #(
		.SB (SB)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.left_in    (left_in),
		.right_in   (right_in),
		.push       (q_push),
		.full       (q_full),
		.push_left  (f_left),
		.push_right (f_right)
	);

	swd_queue #(
		.W (2 * SB)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    ({f_left, f_right}),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	swd_back #(
		.SB    (SB),
		.DEPTH (DELAY_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_left    (q_dout[2*SB-1:SB]),
		.q_right   (q_dout[SB-1:0]),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.left_out  (left_out),
		.right_out (right_out)
	);

	// The front end never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("front end pushed into a full queue");

	// The back end never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back end popped an empty queue");

	// The front end works on one pair at a time: an input transfer drops ready.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("front end ready right after an input transfer");

endmodule

### sim/stereo_matrix_width_delay_test.sv
// Self-checking testbench for the stereo matrix with mid/side width and Haas delay.
module stereo_matrix_width_delay_test;
	import swd_pkg::*;

	localparam int SAMPLE_BITS = 24;
	localparam int DEPTH       = 1024;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYC  = 16;
	localparam int SET_ITEMS   = 100;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;
	// routing code 7 has no name in the package; the block treats it as plain lr
	localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_BITS-1:0] left_in = '0;
	logic signed [SAMPLE_BITS-1:0] right_in = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	stereo_matrix_width_delay #(
		.DELAY_DEPTH(DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.left_in(left_in),
		.right_in(right_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_out(left_out),
		.right_out(right_out)
	);

	// Stimulus and scoreboard state
	pair_t pending_pairs[$];     // pairs waiting for the driver
	pair_t expected_pairs[$];    // predicted outputs, oldest first
	int    pairs_queued = 0;
	int    pairs_accepted = 0;
	int    pairs_checked = 0;
	int    mismatches = 0;
	int    settings_applied = 0;
	logic  in_took = 1'b0;

	// Idling controls, written by the sequence right after a rising edge
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int rx_hold_ask = 0;
	int rx_hold_seen = 0;
	int rx_hold_left = 0;
	int quiet_cycles = 0;

	// Shadow copy of the register file and the two delay rings
	cfg_t shadow_cfg;
	logic signed [SAMPLE_BITS-1:0] left_ring [DEPTH];
	logic signed [SAMPLE_BITS-1:0] right_ring [DEPTH];
	int left_pos;
	int right_pos;

	initial begin
		forever #1 clk = ~clk;
	end

	// Fixed-point helpers: round to nearest with ties away from zero, then clip to 24 bits
	function automatic longint round_shift(input longint x, input int s);
		longint m;
		longint r;
		m = (x < 0) ? -x : x;
		r = (m + (longint'(1) << (s - 1))) >> s;
		return (x < 0) ? -r : r;
	endfunction

	function automatic longint clip_sample(input longint x);
		longint hi;
		hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
		return (x > hi) ? hi : ((x < -hi - 1) ? -hi - 1 : x);
	endfunction

	// Balance attenuates one side; anything past +-1.0 is pinned at +-1.0
	function automatic void scale_balance(input longint b, inout longint l, inout longint r);
		if (b > 32768)
			b = 32768;
		else if (b < -32768)
			b = -32768;
		if (b < 0)
			r = round_shift(r * (32768 + b), BAL_SHIFT);
		else if (b > 0)
			l = round_shift(l * (32768 - b), BAL_SHIFT);
	endfunction

	// Predict one output pair and advance the shadow delay rings
	function automatic pair_t process_pair(input logic signed [SAMPLE_BITS-1:0] l_in,
			input logic signed [SAMPLE_BITS-1:0] r_in);
		longint l;
		longint r;
		longint mid;
		longint side;
		longint wd;
		longint ol;
		longint orr;
		longint dly;
		longint d;
		pair_t y;
		l = l_in;
		r = r_in;
		scale_balance(shadow_cfg.bal_in, l, r);

		mid  = round_shift((l + r) * longint'(shadow_cfg.mid_gain), MS_SHIFT);
		side = round_shift((l - r) * longint'(shadow_cfg.side_gain), MS_SHIFT);
		wd   = round_shift(side * longint'(shadow_cfg.stereo_width), WID_SHIFT);
		ol   = mid + wd;
		orr  = mid - wd;

		case (shadow_cfg.routing_mode)
			MODE_TO_MS: begin
				ol = mid;
				orr = side;
			end
			MODE_MS_TO_LR: begin
				ol = l + r;
				orr = l - r;
			end
			MODE_LL: begin
				ol = l;
				orr = l;
			end
			MODE_RR: begin
				ol = r;
				orr = r;
			end
			MODE_SUM: begin
				ol = l + r;
				orr = l + r;
			end
			MODE_SWAP: begin
				ol = r;
				orr = l;
			end
			default: ;
		endcase
		ol = clip_sample(ol);
		orr = clip_sample(orr);

		// Only the delayed channel writes its ring; the other ring keeps its history
		dly = shadow_cfg.delay_samples;
		d = (dly < 0) ? -dly : dly;
		if (d > MAX_HAAS)
			d = MAX_HAAS;
		if (dly > 0) begin
			right_ring[right_pos] = orr;
			orr = right_ring[(right_pos + DEPTH - d) % DEPTH];
			right_pos = (right_pos + 1) % DEPTH;
		end else if (dly < 0) begin
			left_ring[left_pos] = ol;
			ol = left_ring[(left_pos + DEPTH - d) % DEPTH];
			left_pos = (left_pos + 1) % DEPTH;
		end

		// Invert saturates the most negative sample; mute overrides invert
		if (shadow_cfg.channel_flags[FLAG_INV_L])
			ol = clip_sample(-ol);
		if (shadow_cfg.channel_flags[FLAG_INV_R])
			orr = clip_sample(-orr);
		if (shadow_cfg.channel_flags[FLAG_MUTE_L])
			ol = 0;
		if (shadow_cfg.channel_flags[FLAG_MUTE_R])
			orr = 0;

		scale_balance(shadow_cfg.bal_out, ol, orr);
		y.left = SAMPLE_BITS'(clip_sample(ol));
		y.right = SAMPLE_BITS'(clip_sample(orr));
		return y;
	endfunction

	// Random picks, weighted toward the ends of each range
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(7))
			0: return S_MAX;
			1: return S_MIN;
			2: return SAMPLE_BITS'(int'($urandom_range(512)) - 256);
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	function automatic logic signed [BAL_W-1:0] pick_balance();
		case ($urandom_range(4))
			0: return '0;
			1: return $urandom_range(1) ? BAL_ONE : -BAL_ONE;
			2: return BAL_W'($urandom());
			default: return BAL_W'(int'($urandom_range(65536)) - 32768);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(4))
			0: return GAIN_UNITY;
			1: return '0;
			2: return '1;
			3: return GAIN_W'($urandom());
			default: return GAIN_W'($urandom_range(8192));
		endcase
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.bal_in = pick_balance();
		c.bal_out = pick_balance();
		c.routing_mode = MODE_W'($urandom_range(7));
		c.mid_gain = pick_gain();
		c.side_gain = pick_gain();
		case ($urandom_range(4))
			0: c.stereo_width = WIDTH_UNITY;
			1: c.stereo_width = '0;
			2: c.stereo_width = 16'd32768;
			3: c.stereo_width = '1;
			default: c.stereo_width = WIDTH_W'($urandom());
		endcase
		case ($urandom_range(5))
			0: c.delay_samples = '0;
			1: c.delay_samples = DLY_W'(int'($urandom_range(16)) - 8);
			2: c.delay_samples = DLY_W'($urandom());
			3: c.delay_samples = $urandom_range(1) ? 11'sd960 : -11'sd960;
			default: c.delay_samples = $urandom_range(1) ? 11'sh3FF : 11'sh400;
		endcase
		c.channel_flags = $urandom_range(1) ? '0 : FLAG_W'($urandom_range(15));
		return c;
	endfunction

	// One write transfer: setup cycle, then access cycle until pready
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write the whole register file, then mirror it; only called while the block is idle
	task automatic apply_cfg(input cfg_t c);
		write_reg(REG_BAL_IN, DATA_W'(c.bal_in));
		write_reg(REG_BAL_OUT, DATA_W'(c.bal_out));
		write_reg(REG_MODE, DATA_W'(c.routing_mode));
		write_reg(REG_MID, DATA_W'(c.mid_gain));
		write_reg(REG_SIDE, DATA_W'(c.side_gain));
		write_reg(REG_WIDTH, DATA_W'(c.stereo_width));
		write_reg(REG_DELAY, DATA_W'(c.delay_samples));
		write_reg(REG_FLAGS, DATA_W'(c.channel_flags));
		shadow_cfg = c;
		settings_applied++;
	endtask

	// Called right after a rising edge so the driver never races the push
	task automatic queue_pair(input logic signed [SAMPLE_BITS-1:0] l,
			input logic signed [SAMPLE_BITS-1:0] r);
		pair_t p;
		p.left = l;
		p.right = r;
		pending_pairs.push_back(p);
		pairs_queued++;
	endtask

	// Hold the sequence until every queued pair is accepted and checked, then let the block settle
	task automatic settle();
		while (pairs_accepted != pairs_queued || expected_pairs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	// Sender: advance to the next pair only once the current one has transferred
	always @(negedge clk) begin
		pair_t p;
		if (!in_valid || in_took) begin
			if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				p = pending_pairs.pop_front();
				in_valid <= 1'b1;
				left_in <= p.left;
				right_in <= p.right;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a requested hold is counted down here, otherwise stall at random
	always @(negedge clk) begin
		if (rx_hold_seen != rx_hold_ask) begin
			rx_hold_seen = rx_hold_ask;
			rx_hold_left = 400;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predict on every input transfer, check on every output transfer
	always @(posedge clk) begin : monitor
		pair_t want;
		in_took <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			expected_pairs.push_back(process_pair(left_in, right_in));
			pairs_accepted++;
		end
		if (out_valid && out_ready) begin
			if (expected_pairs.size() == 0) begin
				if (mismatches < 10)
					$display("output %0d: unexpected pair left %0d right %0d",
						pairs_checked, left_out, right_out);
				mismatches++;
			end else begin
				want = expected_pairs.pop_front();
				if (left_out !== want.left || right_out !== want.right) begin
					if (mismatches < 10)
						$display("output %0d: left exp %0d got %0d, right exp %0d got %0d",
							pairs_checked, want.left, left_out, want.right, right_out);
					mismatches++;
				end
			end
			pairs_checked++;
		end
	end

	// Watchdog: any input, output or register-write transfer counts as progress
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(psel && penable && pwrite && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d pairs still expected",
				quiet_cycles, expected_pairs.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Sequence
	initial begin
		cfg_t c;
		cfg_t base;
		int m;
		int p;
		int s;
		int k;

		// Power-on register values and empty rings
		base.bal_in = '0;
		base.bal_out = '0;
		base.routing_mode = MODE_LR;
		base.mid_gain = GAIN_UNITY;
		base.side_gain = GAIN_UNITY;
		base.stereo_width = WIDTH_UNITY;
		base.delay_samples = '0;
		base.channel_flags = '0;
		shadow_cfg = base;
		for (k = 0; k < DEPTH; k++) begin
			left_ring[k] = '0;
			right_ring[k] = '0;
		end
		left_pos = 0;
		right_pos = 0;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: full-scale pairs on the power-on settings, some of which saturate in lr
		@(posedge clk);
		queue_pair(S_MAX, S_MAX);
		queue_pair(S_MIN, S_MIN);
		queue_pair(S_MAX, S_MIN);
		queue_pair(S_MIN, S_MAX);
		queue_pair(24'sd1, -24'sd1);
		settle();

		// Directed: every named routing mode other than lr
		for (m = MODE_TO_MS; m <= MODE_SWAP; m++) begin
			c = base;
			c.routing_mode = MODE_W'(m);
			apply_cfg(c);
			@(posedge clk);
			queue_pair(S_MAX, S_MIN);
			queue_pair(pick_sample(), pick_sample());
			settle();
		end

		// Directed: out-of-range balances, spare routing code, width near 4.0,
		// delay past the limit on the right, left muted and both inverted
		c = base;
		c.bal_in = 17'sd40000;
		c.bal_out = 17'sh10000;
		c.routing_mode = MODE_SPARE;
		c.stereo_width = '1;
		c.delay_samples = 11'sh3FF;
		c.channel_flags = '0;
		c.channel_flags[FLAG_INV_L] = 1'b1;
		c.channel_flags[FLAG_INV_R] = 1'b1;
		c.channel_flags[FLAG_MUTE_L] = 1'b1;
		apply_cfg(c);
		@(posedge clk);
		queue_pair(S_MIN, S_MIN);
		queue_pair(S_MIN, S_MAX);
		queue_pair(S_MAX, 24'sd0);
		settle();

		// Directed: most negative left delay, mute on top of invert on both sides
		c.delay_samples = 11'sh400;
		c.channel_flags = '1;
		apply_cfg(c);
		@(posedge clk);
		queue_pair(S_MAX, S_MIN);
		queue_pair(S_MIN, S_MAX);
		settle();

		// Directed: invert of the most negative sample saturates to full positive
		c = base;
		c.channel_flags[FLAG_INV_L] = 1'b1;
		c.channel_flags[FLAG_INV_R] = 1'b1;
		apply_cfg(c);
		@(posedge clk);
		queue_pair(S_MIN, S_MIN);
		queue_pair(S_MAX, S_MAX);
		settle();

		// Random: four idling phases, a handful of register settings in each
		for (p = 0; p < 4; p++) begin
			for (s = 0; s < 5; s++) begin
				c = random_cfg();
				apply_cfg(c);
				@(posedge clk);
				case (p)
					0: begin
						send_idle_pct = 0;
						recv_stall_pct = 0;
					end
					1: begin
						send_idle_pct = 82;
						recv_stall_pct = 0;
					end
					2: begin
						send_idle_pct = 0;
						recv_stall_pct = 82;
					end
					default: begin
						send_idle_pct = 35;
						recv_stall_pct = 35;
					end
				endcase
				for (k = 0; k < SET_ITEMS; k++)
					queue_pair(pick_sample(), pick_sample());
				// long receiver hold while the sender keeps offering: fill the block
				if (p == 0 && s == 1)
					rx_hold_ask++;
				settle();
			end
		end

		$display("ran %0d stereo pairs over %0d register settings (all routing codes,",
			pairs_accepted, settings_applied);
		$display("  balance/gain/width/delay extremes, idle and stall mixes); %0d checked",
			pairs_checked);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
rtl/swd_pkg.sv
rtl/swd_front.sv
rtl/swd_queue.sv
rtl/swd_back.sv
rtl/stereo_matrix_width_delay.sv
sim/stereo_matrix_width_delay_test.sv
